// ----- hdl/cc_pkg.sv -----
package cc_pkg;

  // Coordinate and register widths.
  localparam int CoordW = 32;
  localparam int TolW   = 32;

  // Exact intermediate widths of the circumcenter datapath.
  localparam int DiffW  = CoordW + 1;          // differences and pair sums
  localparam int ProdW  = 2 * DiffW;           // products of two differences
  localparam int EfW    = ProdW + 1;           // E and F
  localparam int GW     = EfW + 1;             // G, including the factor of two
  localparam int SplitW = DiffW + 1;           // low slice of E and F
  localparam int HiW    = EfW - SplitW;        // high slice of E and F
  localparam int LoPW   = DiffW + SplitW + 1;  // difference times low slice
  localparam int HxW    = DiffW + HiW + 1;     // high partial numerator
  localparam int LxW    = LoPW + 1;            // low partial numerator
  localparam int NumW   = DiffW + EfW + 1;     // full numerator

  // Divider and square root widths.
  localparam int QuoW   = CoordW + 3;          // quotient bits developed
  localparam int RemW   = GW + QuoW;           // partial remainder
  localparam int CenW   = QuoW + 1;            // rounded, signed center
  localparam int RootW  = CoordW;              // radius
  localparam int SqW    = 2 * RootW;           // squared distance

  // Rounded centers at or beyond this magnitude put the radius out of range.
  localparam logic [CenW-1:0] FarLim = CenW'(1) << (QuoW - 1);

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
    coord_t x2;
    coord_t y2;
  } pts_t;

  typedef struct packed {
    coord_t x0;
    coord_t y0;
    logic   colin;
  } side_t;

  typedef struct packed {
    logic [NumW-1:0] nx_abs;
    logic [NumW-1:0] ny_abs;
    logic [GW-1:0]   g_abs;
    logic            x_neg;
    logic            y_neg;
    side_t           side;
  } quo_req_t;

  typedef struct packed {
    logic signed [CenW-1:0] cx;
    logic signed [CenW-1:0] cy;
    logic                   far;
    side_t                  side;
  } cen_t;

  typedef struct packed {
    logic signed [CenW-1:0] cx;
    logic signed [CenW-1:0] cy;
    logic [RootW-1:0]       rad;
    logic                   rsat;
    logic                   colin;
  } rad_t;

endpackage

// ----- hdl/cc_front.sv -----
module cc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [cc_pkg::TolW-1:0] tol_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cc_pkg::pts_t      pts_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cc_pkg::quo_req_t  req_o
);
  import cc_pkg::*;

  localparam int NumStg = 7;

  logic [NumStg-1:0] vld_q;
  logic [NumStg-1:0] vld_in;
  logic [NumStg:0]   go;

  assign go[NumStg] = out_ready_i;
  for (genvar k = 0; k < NumStg; k++) begin : g_go
    assign go[k] = !vld_q[k] || go[k+1];
  end
  assign vld_in = {vld_q[NumStg-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NumStg; k++) begin
        if (go[k]) begin
          vld_q[k] <= vld_in[k];
        end
      end
    end
  end

  // First point travels alongside for the radius.
  coord_t x0_q [NumStg-1];
  coord_t y0_q [NumStg-1];

  always_ff @(posedge clk_i) begin
    if (go[0]) begin
      x0_q[0] <= pts_i.x0;
      y0_q[0] <= pts_i.y0;
    end
    for (int k = 1; k < NumStg - 1; k++) begin
      if (go[k]) begin
        x0_q[k] <= x0_q[k-1];
        y0_q[k] <= y0_q[k-1];
      end
    end
  end

  // Stage 0: differences and pair sums.
  logic signed [DiffW-1:0] a_q, b_q, c_q, d_q, s1_q, s2_q, s3_q, s4_q, u_q, v_q;

  always_ff @(posedge clk_i) begin
    if (go[0]) begin
      a_q  <= DiffW'(pts_i.x1) - DiffW'(pts_i.x0);
      b_q  <= DiffW'(pts_i.y1) - DiffW'(pts_i.y0);
      c_q  <= DiffW'(pts_i.x2) - DiffW'(pts_i.x0);
      d_q  <= DiffW'(pts_i.y2) - DiffW'(pts_i.y0);
      s1_q <= DiffW'(pts_i.x0) + DiffW'(pts_i.x1);
      s2_q <= DiffW'(pts_i.y0) + DiffW'(pts_i.y1);
      s3_q <= DiffW'(pts_i.x0) + DiffW'(pts_i.x2);
      s4_q <= DiffW'(pts_i.y0) + DiffW'(pts_i.y2);
      u_q  <= DiffW'(pts_i.y2) - DiffW'(pts_i.y1);
      v_q  <= DiffW'(pts_i.x2) - DiffW'(pts_i.x1);
    end
  end

  // Stage 1: six products of differences.
  logic signed [ProdW-1:0] pa_q, pb_q, pc_q, pd_q, pg1_q, pg2_q;
  logic signed [DiffW-1:0] a1_q, b1_q, c1_q, d1_q;

  always_ff @(posedge clk_i) begin
    if (go[1]) begin
      pa_q  <= a_q * s1_q;
      pb_q  <= b_q * s2_q;
      pc_q  <= c_q * s3_q;
      pd_q  <= d_q * s4_q;
      pg1_q <= a_q * u_q;
      pg2_q <= b_q * v_q;
      a1_q  <= a_q;
      b1_q  <= b_q;
      c1_q  <= c_q;
      d1_q  <= d_q;
    end
  end

  // Stage 2: E, F and G.
  logic signed [EfW-1:0]   e_q, f_q, g_half;
  logic signed [GW-1:0]    g_q;
  logic signed [DiffW-1:0] a2_q, b2_q, c2_q, d2_q;

  assign g_half = EfW'(pg1_q) - EfW'(pg2_q);

  always_ff @(posedge clk_i) begin
    if (go[2]) begin
      e_q  <= EfW'(pa_q) + EfW'(pb_q);
      f_q  <= EfW'(pc_q) + EfW'(pd_q);
      g_q  <= {g_half, 1'b0};
      a2_q <= a1_q;
      b2_q <= b1_q;
      c2_q <= c1_q;
      d2_q <= d1_q;
    end
  end

  // Stage 3: numerator partial products on split E and F, and |G|.
  logic signed [HiW-1:0]    e_hi, f_hi;
  logic signed [SplitW:0]   e_lo, f_lo;
  logic signed [ProdW-1:0]  deh_q, bfh_q, afh_q, ceh_q;
  logic signed [LoPW-1:0]   del_q, bfl_q, afl_q, cel_q;
  logic [GW-1:0]            g_abs3_q;
  logic                     g_neg3_q;

  assign e_hi = e_q[EfW-1:SplitW];
  assign f_hi = f_q[EfW-1:SplitW];
  assign e_lo = {1'b0, e_q[SplitW-1:0]};
  assign f_lo = {1'b0, f_q[SplitW-1:0]};

  always_ff @(posedge clk_i) begin
    if (go[3]) begin
      deh_q    <= d2_q * e_hi;
      bfh_q    <= b2_q * f_hi;
      afh_q    <= a2_q * f_hi;
      ceh_q    <= c2_q * e_hi;
      del_q    <= d2_q * e_lo;
      bfl_q    <= b2_q * f_lo;
      afl_q    <= a2_q * f_lo;
      cel_q    <= c2_q * e_lo;
      g_abs3_q <= g_q[GW-1] ? -g_q : g_q;
      g_neg3_q <= g_q[GW-1];
    end
  end

  // Stage 4: high and low numerator halves, tolerance compare.
  logic signed [HxW-1:0] hx_q, hy_q;
  logic signed [LxW-1:0] lx_q, ly_q;
  logic [GW-1:0]         g_abs4_q;
  logic                  g_neg4_q, colin4_q;

  always_ff @(posedge clk_i) begin
    if (go[4]) begin
      hx_q     <= HxW'(deh_q) - HxW'(bfh_q);
      lx_q     <= LxW'(del_q) - LxW'(bfl_q);
      hy_q     <= HxW'(afh_q) - HxW'(ceh_q);
      ly_q     <= LxW'(afl_q) - LxW'(cel_q);
      g_abs4_q <= g_abs3_q;
      g_neg4_q <= g_neg3_q;
      colin4_q <= g_abs3_q <= GW'(tol_i);
    end
  end

  // Stage 5: full numerators.
  logic signed [NumW-1:0] nx_q, ny_q;
  logic [GW-1:0]          g_abs5_q;
  logic                   g_neg5_q, colin5_q;

  always_ff @(posedge clk_i) begin
    if (go[5]) begin
      nx_q     <= (NumW'(hx_q) <<< SplitW) + NumW'(lx_q);
      ny_q     <= (NumW'(hy_q) <<< SplitW) + NumW'(ly_q);
      g_abs5_q <= g_abs4_q;
      g_neg5_q <= g_neg4_q;
      colin5_q <= colin4_q;
    end
  end

  // Stage 6: magnitudes and quotient signs for the divider.
  quo_req_t req_q;

  always_ff @(posedge clk_i) begin
    if (go[6]) begin
      req_q.nx_abs     <= nx_q[NumW-1] ? -nx_q : nx_q;
      req_q.ny_abs     <= ny_q[NumW-1] ? -ny_q : ny_q;
      req_q.g_abs      <= g_abs5_q;
      req_q.x_neg      <= nx_q[NumW-1] ^ g_neg5_q;
      req_q.y_neg      <= ny_q[NumW-1] ^ g_neg5_q;
      req_q.side.x0    <= x0_q[NumStg-2];
      req_q.side.y0    <= y0_q[NumStg-2];
      req_q.side.colin <= colin5_q;
    end
  end

  assign in_ready_o  = go[0];
  assign out_valid_o = vld_q[NumStg-1];
  assign req_o       = req_q;

endmodule

// ----- hdl/cc_div.sv -----
module cc_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  cc_pkg::quo_req_t req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output cc_pkg::cen_t     cen_o
);
  import cc_pkg::*;

  // One range check stage, one stage per quotient bit, one rounding stage.
  localparam int NumStg = QuoW + 2;

  typedef struct packed {
    logic [RemW-1:0] px;
    logic [RemW-1:0] py;
    logic [QuoW-1:0] qx;
    logic [QuoW-1:0] qy;
    logic            farx;
    logic            fary;
    logic [GW-1:0]   g;
    logic            xn;
    logic            yn;
    side_t           side;
  } lane_t;

  logic [NumStg-1:0] vld_q;
  logic [NumStg-1:0] vld_in;
  logic [NumStg:0]   go;

  assign go[NumStg] = out_ready_i;
  for (genvar k = 0; k < NumStg; k++) begin : g_go
    assign go[k] = !vld_q[k] || go[k+1];
  end
  assign vld_in = {vld_q[NumStg-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NumStg; k++) begin
        if (go[k]) begin
          vld_q[k] <= vld_in[k];
        end
      end
    end
  end

  lane_t st_q [QuoW+1];
  lane_t st0;

  // A quotient of 2^QuoW or more is flagged here, and the rounding stage replaces it by the limit.
  always_comb begin
    st0      = '0;
    st0.px   = RemW'(req_i.nx_abs);
    st0.py   = RemW'(req_i.ny_abs);
    st0.farx = RemW'(req_i.nx_abs) >= (RemW'(req_i.g_abs) << QuoW);
    st0.fary = RemW'(req_i.ny_abs) >= (RemW'(req_i.g_abs) << QuoW);
    st0.g    = req_i.g_abs;
    st0.xn   = req_i.x_neg;
    st0.yn   = req_i.y_neg;
    st0.side = req_i.side;
  end

  always_ff @(posedge clk_i) begin
    if (go[0]) begin
      st_q[0] <= st0;
    end
  end

  for (genvar j = 1; j <= QuoW; j++) begin : g_bit
    localparam int Bit = QuoW - j;
    logic [RemW-1:0] trial;
    lane_t           nxt;

    always_comb begin
      trial = RemW'(st_q[j-1].g) << Bit;
      nxt   = st_q[j-1];
      if (st_q[j-1].px >= trial) begin
        nxt.px      = st_q[j-1].px - trial;
        nxt.qx[Bit] = 1'b1;
      end
      if (st_q[j-1].py >= trial) begin
        nxt.py      = st_q[j-1].py - trial;
        nxt.qy[Bit] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (go[j]) begin
        st_q[j] <= nxt;
      end
    end
  end

  // Round half away from zero on the magnitude, then limit and apply the sign.
  lane_t           fin;
  logic [CenW-1:0] rx, ry;
  logic            fx, fy;
  cen_t            cen_d, cen_q;

  always_comb begin
    fin = st_q[QuoW];
    rx  = {1'b0, fin.qx} + CenW'({fin.px[GW-1:0], 1'b0} >= {1'b0, fin.g});
    ry  = {1'b0, fin.qy} + CenW'({fin.py[GW-1:0], 1'b0} >= {1'b0, fin.g});
    fx  = fin.farx || (rx >= FarLim);
    fy  = fin.fary || (ry >= FarLim);
    cen_d.cx   = fx ? (fin.xn ? -FarLim : FarLim) : (fin.xn ? -rx : rx);
    cen_d.cy   = fy ? (fin.yn ? -FarLim : FarLim) : (fin.yn ? -ry : ry);
    cen_d.far  = fx || fy;
    cen_d.side = fin.side;
  end

  always_ff @(posedge clk_i) begin
    if (go[NumStg-1]) begin
      cen_q <= cen_d;
    end
  end

  assign in_ready_o  = go[0];
  assign out_valid_o = vld_q[NumStg-1];
  assign cen_o       = cen_q;

endmodule

// ----- hdl/cc_sqrt.sv -----
module cc_sqrt (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  cc_pkg::cen_t cen_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output cc_pkg::rad_t rad_o
);
  import cc_pkg::*;

  // Distance, squares, sum, one stage per root bit, rounding.
  localparam int NumStg = RootW + 4;
  localparam int PassN  = RootW + 3;
  localparam int TrW    = SqW + 2;

  typedef struct packed {
    logic signed [CenW-1:0] cx;
    logic signed [CenW-1:0] cy;
    logic                   rsat;
    logic                   colin;
  } pass_t;

  typedef struct packed {
    logic [SqW-1:0]   rem;
    logic [RootW-1:0] root;
  } sq_t;

  logic [NumStg-1:0] vld_q;
  logic [NumStg-1:0] vld_in;
  logic [NumStg:0]   go;

  assign go[NumStg] = out_ready_i;
  for (genvar k = 0; k < NumStg; k++) begin : g_go
    assign go[k] = !vld_q[k] || go[k+1];
  end
  assign vld_in = {vld_q[NumStg-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NumStg; k++) begin
        if (go[k]) begin
          vld_q[k] <= vld_in[k];
        end
      end
    end
  end

  pass_t pass_q [PassN];

  // Stage 0: distances from the first point to the center.
  logic signed [CenW:0] ddx, ddy;
  logic [CenW:0]        adx, ady;
  logic [RootW-1:0]     dx_q, dy_q;
  pass_t                p0;

  always_comb begin
    ddx      = (CenW+1)'(cen_i.side.x0) - (CenW+1)'(cen_i.cx);
    ddy      = (CenW+1)'(cen_i.side.y0) - (CenW+1)'(cen_i.cy);
    adx      = ddx[CenW] ? -ddx : ddx;
    ady      = ddy[CenW] ? -ddy : ddy;
    p0.cx    = cen_i.cx;
    p0.cy    = cen_i.cy;
    p0.colin = cen_i.side.colin;
    p0.rsat  = cen_i.far || (|adx[CenW:RootW]) || (|ady[CenW:RootW]);
  end

  always_ff @(posedge clk_i) begin
    if (go[0]) begin
      dx_q       <= adx[RootW-1:0];
      dy_q       <= ady[RootW-1:0];
      pass_q[0]  <= p0;
    end
  end

  // Stage 1: squares.
  logic [SqW-1:0] sx_q, sy_q;

  always_ff @(posedge clk_i) begin
    if (go[1]) begin
      sx_q      <= dx_q * dx_q;
      sy_q      <= dy_q * dy_q;
      pass_q[1] <= pass_q[0];
    end
  end

  // Stage 2: sum of squares with carry-out check.
  logic [SqW:0] ssum;
  pass_t        p2;
  sq_t          it_q [RootW+1];

  always_comb begin
    ssum    = {1'b0, sx_q} + {1'b0, sy_q};
    p2      = pass_q[1];
    p2.rsat = pass_q[1].rsat || ssum[SqW];
  end

  always_ff @(posedge clk_i) begin
    if (go[2]) begin
      it_q[0].rem  <= ssum[SqW-1:0];
      it_q[0].root <= '0;
      pass_q[2]    <= p2;
    end
  end

  // Root bits, most significant first; rem stays equal to s - root^2.
  for (genvar j = 1; j <= RootW; j++) begin : g_root
    localparam int Bit = RootW - j;
    logic [TrW-1:0] trial;
    sq_t            nxt;

    always_comb begin
      trial = (TrW'(it_q[j-1].root) << (Bit + 1)) + (TrW'(1) << (2 * Bit));
      nxt   = it_q[j-1];
      if (TrW'(it_q[j-1].rem) >= trial) begin
        nxt.rem       = it_q[j-1].rem - trial[SqW-1:0];
        nxt.root[Bit] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (go[2+j]) begin
        it_q[j]     <= nxt;
        pass_q[2+j] <= pass_q[1+j];
      end
    end
  end

  // Final stage: round to nearest.
  logic [RootW:0] rr;
  rad_t           rad_d, rad_q;

  always_comb begin
    rr          = {1'b0, it_q[RootW].root} +
                  (RootW+1)'(SqW'(it_q[RootW].root) < it_q[RootW].rem);
    rad_d.cx    = pass_q[PassN-1].cx;
    rad_d.cy    = pass_q[PassN-1].cy;
    rad_d.rad   = rr[RootW-1:0];
    rad_d.rsat  = pass_q[PassN-1].rsat || rr[RootW];
    rad_d.colin = pass_q[PassN-1].colin;
  end

  always_ff @(posedge clk_i) begin
    if (go[NumStg-1]) begin
      rad_q <= rad_d;
    end
  end

  assign in_ready_o  = go[0];
  assign out_valid_o = vld_q[NumStg-1];
  assign rad_o       = rad_q;

endmodule

// ----- hdl/circumcircle_xy.sv -----
// Channel   Direction  Handshake                 Payload
// config    in         cfg_we_i                  cfg_wdata_i (collinear tolerance)
// request   in         in_valid_i / in_stall_o   first_x_i .. third_y_i
// result    out        out_valid_o / out_stall_i center_x_o, center_y_o, radius_o,
//                                                collinear_o, saturated_o
//
// One request is taken per cycle while in_stall_o is low. It passes 81 register
// stages: seven front stages, 37 divider stages (range check, one per quotient
// bit, rounding) and 36 square root stages (distance, squares, sum, one per root
// bit, rounding), then the output register.
// Reset clears the valid bits of every stage and the tolerance register.
// A stalled result holds the output register; empty stages behind it keep filling,
// so requests are still taken until the pipeline is full.
module circumcircle_xy (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cc_pkg::TolW-1:0]          cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [cc_pkg::CoordW-1:0] first_x_i,
  input  logic signed [cc_pkg::CoordW-1:0] first_y_i,
  input  logic signed [cc_pkg::CoordW-1:0] second_x_i,
  input  logic signed [cc_pkg::CoordW-1:0] second_y_i,
  input  logic signed [cc_pkg::CoordW-1:0] third_x_i,
  input  logic signed [cc_pkg::CoordW-1:0] third_y_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [cc_pkg::CoordW-1:0] center_x_o,
  output logic signed [cc_pkg::CoordW-1:0] center_y_o,
  output logic [cc_pkg::CoordW-1:0]        radius_o,
  output logic                             collinear_o,
  output logic                             saturated_o
);
  import cc_pkg::*;

  localparam logic signed [CenW-1:0] CMax = CenW'((64'(1) << (CoordW - 1)) - 64'(1));
  localparam logic signed [CenW-1:0] CMin = -CMax - CenW'(1);

  // The user must write the tolerance register only while the pipeline is empty; the block does not enforce it.
  logic [TolW-1:0] tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  pts_t     pts;
  quo_req_t req;
  cen_t     cen;
  rad_t     rad;
  logic     fr_ready, fr_valid, dv_ready, dv_valid, sq_ready, sq_valid, out_go;

  assign pts.x0 = first_x_i;
  assign pts.y0 = first_y_i;
  assign pts.x1 = second_x_i;
  assign pts.y1 = second_y_i;
  assign pts.x2 = third_x_i;
  assign pts.y2 = third_y_i;

  // Exact E, F, G and both numerators.
  cc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tol_i       (tol_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (fr_ready),
    .pts_i       (pts),
    .out_valid_o (fr_valid),
    .out_ready_i (dv_ready),
    .req_o       (req)
  );

  // Both center coordinates, divided side by side.
  cc_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (dv_ready),
    .req_i       (req),
    .out_valid_o (dv_valid),
    .out_ready_i (sq_ready),
    .cen_o       (cen)
  );

  // Distance to the first point and its rounded square root.
  cc_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (dv_valid),
    .in_ready_o  (sq_ready),
    .cen_i       (cen),
    .out_valid_o (sq_valid),
    .out_ready_i (out_go),
    .rad_o       (rad)
  );

  assign in_stall_o = !fr_ready;

  // Output register: clamp the centers, saturate the radius, zero collinear results.
  logic                     out_vld_q;
  logic signed [CoordW-1:0] cx_d, cy_d, cx_q, cy_q;
  logic [CoordW-1:0]        r_d, r_q;
  logic                     col_q, sat_d, sat_q;
  logic                     clx, cly;

  assign out_go = !out_vld_q || !out_stall_i;

  always_comb begin
    clx = (rad.cx > CMax) || (rad.cx < CMin);
    cly = (rad.cy > CMax) || (rad.cy < CMin);
    if (rad.cx > CMax) begin
      cx_d = CMax[CoordW-1:0];
    end else if (rad.cx < CMin) begin
      cx_d = CMin[CoordW-1:0];
    end else begin
      cx_d = rad.cx[CoordW-1:0];
    end
    if (rad.cy > CMax) begin
      cy_d = CMax[CoordW-1:0];
    end else if (rad.cy < CMin) begin
      cy_d = CMin[CoordW-1:0];
    end else begin
      cy_d = rad.cy[CoordW-1:0];
    end
    r_d   = rad.rsat ? '1 : rad.rad;
    sat_d = rad.rsat || clx || cly;
    if (rad.colin) begin
      cx_d  = '0;
      cy_d  = '0;
      r_d   = '0;
      sat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_go) begin
      out_vld_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_go) begin
      cx_q  <= cx_d;
      cy_q  <= cy_d;
      r_q   <= r_d;
      col_q <= rad.colin;
      sat_q <= sat_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign center_x_o  = cx_q;
  assign center_y_o  = cy_q;
  assign radius_o    = r_q;
  assign collinear_o = col_q;
  assign saturated_o = sat_q;

  // Requests back up only when a finished result is held at the output.
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("request stalled without a held result");

  // A collinear result carries only zeros.
  a_colin_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && collinear_o) |->
      (center_x_o == '0 && center_y_o == '0 && radius_o == '0 && !saturated_o))
    else $error("collinear result is not all zero");

  // A held result keeps its center x, radius and saturated flag while the pipeline behind it fills.
  a_hold_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      ($stable(center_x_o) && $stable(radius_o) && $stable(saturated_o)))
    else $error("held result changed");

endmodule

// ----- test/circumcircle_xy_tb.sv -----
`timescale 1ns / 1ps

// Checks circumcircle_xy against a local model of the exact datapath:
// exact E, F and G, the collinear test against the tolerance register, the two
// centre quotients rounded to nearest with ties away from zero, the rounded
// square root for the radius, and saturation of all three results.
// A short table of hand-picked triangles runs first, then random triangles in
// several tolerance phases, with random idling on both sides, one long output
// hold-off that fills the pipeline, and a full drain before each register write.
module circumcircle_xy_tb;
  import cc_pkg::*;

  // One result of the block, in the order of its output ports.
  typedef struct packed {
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic [CoordW-1:0]        rad;
    logic                     colin;
    logic                     sat;
  } circle_t;

  // One row of the directed table. When fixed is set the expected result is
  // the one typed into the row; otherwise the model works it out.
  typedef struct {
    pts_t    pts;
    logic    fixed;
    circle_t res;
  } row_t;

  localparam logic signed [127:0] FarMag  = 128'sd1 <<< 34;
  localparam logic signed [127:0] DiffMag = 128'sd1 <<< 32;
  localparam coord_t CMax  = 32'sh7fff_ffff;
  localparam coord_t CMin  = 32'sh8000_0000;
  localparam coord_t One   = 32'sh0001_0000;
  localparam int     IdlePct     = 38;
  localparam int     HoldCycles  = 400;
  localparam int     DrainCycles = 100;
  localparam int     WatchLimit  = 3000;
  localparam int     RandPerPhase = 410;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [TolW-1:0]  cfg_wdata_i;
  logic             in_valid_i;
  logic             in_stall_o;
  coord_t           first_x_i, first_y_i, second_x_i, second_y_i, third_x_i, third_y_i;
  logic             out_valid_o;
  logic             out_stall_i;
  coord_t           center_x_o, center_y_o;
  logic [CoordW-1:0] radius_o;
  logic             collinear_o;
  logic             saturated_o;

  circumcircle_xy u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .first_x_i   (first_x_i),
    .first_y_i   (first_y_i),
    .second_x_i  (second_x_i),
    .second_y_i  (second_y_i),
    .third_x_i   (third_x_i),
    .third_y_i   (third_y_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .center_x_o  (center_x_o),
    .center_y_o  (center_y_o),
    .radius_o    (radius_o),
    .collinear_o (collinear_o),
    .saturated_o (saturated_o)
  );

  circle_t         circles_due[$];   // expected results, oldest first
  logic [TolW-1:0] tolerance;        // local copy of the register
  logic            calm;             // no idling on either side while set
  logic            hold_req;         // asks the receiver for one long hold-off
  int              errors;
  int              results_seen;
  int              collinear_seen;
  int              saturated_seen;
  int              quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Signed division rounded to nearest, ties away from zero. The divisor is
  // never zero because a zero G always counts as collinear.
  function automatic logic signed [127:0] div_nearest(logic signed [127:0] num,
                                                      logic signed [127:0] den);
    logic signed [127:0] un, ud, q, rm;
    logic                neg;
    neg = (num < 0) != (den < 0);
    un  = (num < 0) ? -num : num;
    ud  = (den < 0) ? -den : den;
    q   = un / ud;
    rm  = un % ud;
    if (2 * rm >= ud) q = q + 1;
    return neg ? -q : q;
  endfunction

  // Integer square root rounded to nearest, digit by digit.
  function automatic logic [63:0] sqrt_nearest(logic [63:0] v);
    logic [63:0] op, res, bitv;
    op   = v;
    res  = '0;
    bitv = 64'd1 << 62;
    while (bitv > op) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (op >= res + bitv) begin
        op  = op - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    if (op > res) res = res + 1;
    return res;
  endfunction

  // Centre and radius of the circle through the three points, bit exact.
  function automatic circle_t predict_circle(pts_t p, logic [TolW-1:0] tol);
    logic signed [127:0] x0, y0, x1, y1, x2, y2, a, b, c, d, e, f, g, ag;
    logic signed [127:0] qx, qy, cx, cy, dx, dy;
    logic [64:0]         s;
    logic [63:0]         root;
    logic                rsat;
    circle_t             r;
    r  = '0;
    x0 = p.x0;  y0 = p.y0;
    x1 = p.x1;  y1 = p.y1;
    x2 = p.x2;  y2 = p.y2;
    a  = x1 - x0;  b = y1 - y0;
    c  = x2 - x0;  d = y2 - y0;
    e  = a * (x0 + x1) + b * (y0 + y1);
    f  = c * (x0 + x2) + d * (y0 + y2);
    g  = 2 * (a * (y2 - y1) - b * (x2 - x1));
    ag = (g < 0) ? -g : g;
    if (ag <= $signed({96'd0, tol})) begin
      r.colin = 1'b1;
      return r;
    end
    qx = div_nearest(d * e - b * f, g);
    qy = div_nearest(a * f - c * e, g);
    rsat = 1'b0;
    // A centre this far out already puts the radius beyond its range.
    if (qx >= FarMag || qx <= -FarMag || qy >= FarMag || qy <= -FarMag) rsat = 1'b1;
    cx = (qx >= FarMag) ? FarMag : (qx <= -FarMag) ? -FarMag : qx;
    cy = (qy >= FarMag) ? FarMag : (qy <= -FarMag) ? -FarMag : qy;
    if (!rsat) begin
      dx = (x0 - cx < 0) ? cx - x0 : x0 - cx;
      dy = (y0 - cy < 0) ? cy - y0 : y0 - cy;
      if (dx >= DiffMag || dy >= DiffMag) begin
        rsat = 1'b1;
      end else begin
        s = dx[63:0] * dx[63:0] + dy[63:0] * dy[63:0];
        if (s[64]) begin
          rsat = 1'b1;
        end else begin
          root = sqrt_nearest(s[63:0]);
          if (root > 64'hffff_ffff) rsat = 1'b1;
          r.rad = root[31:0];
        end
      end
    end
    if (rsat) begin
      r.rad = '1;
      r.sat = 1'b1;
    end
    // The centre is clamped to the coordinate range on its own.
    if (cx > CMax) begin
      cx = CMax;  r.sat = 1'b1;
    end else if (cx < CMin) begin
      cx = CMin;  r.sat = 1'b1;
    end
    if (cy > CMax) begin
      cy = CMax;  r.sat = 1'b1;
    end else if (cy < CMin) begin
      cy = CMin;  r.sat = 1'b1;
    end
    r.cx = cx[31:0];
    r.cy = cy[31:0];
    return r;
  endfunction

  function automatic logic idle_now();
    return !calm && ($urandom_range(0, 99) < IdlePct);
  endfunction

  // Offers one request and waits until the block takes it. The expected
  // result is queued at the edge of acceptance.
  task automatic send_request(pts_t p, logic fixed, circle_t res);
    @(negedge clk_i);
    while (idle_now()) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    first_x_i  <= p.x0;  first_y_i  <= p.y0;
    second_x_i <= p.x1;  second_y_i <= p.y1;
    third_x_i  <= p.x2;  third_y_i  <= p.y2;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    circles_due.push_back(fixed ? res : predict_circle(p, tolerance));
  endtask

  // Lowers valid, waits for every outstanding result and lets the pipeline
  // settle before anything else happens.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (circles_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Writes the tolerance register; the block is idle here.
  task automatic set_tolerance(logic [TolW-1:0] v);
    drain();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    tolerance = v;
  endtask

  function automatic coord_t rand_coord(int shift);
    return $signed($urandom) >>> shift;
  endfunction

  // Random triangles of several shapes: full range, modest size, nearly
  // collinear, and with each coordinate of the third point copied from another point.
  function automatic pts_t random_points();
    pts_t   p;
    coord_t dxv, dyv;
    int     shape, sh, k;
    shape = $urandom_range(0, 9);
    sh    = $urandom_range(0, 31);
    p.x0 = rand_coord(sh);  p.y0 = rand_coord(sh);
    p.x1 = rand_coord(sh);  p.y1 = rand_coord(sh);
    p.x2 = rand_coord(sh);  p.y2 = rand_coord(sh);
    if (shape < 2) begin
      p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else if (shape < 5) begin
      dxv  = rand_coord($urandom_range(12, 24));
      dyv  = rand_coord($urandom_range(12, 24));
      k    = $urandom_range(0, 6) - 3;
      p.x0 = rand_coord(4);
      p.y0 = rand_coord(4);
      p.x1 = p.x0 + dxv;
      p.y1 = p.y0 + dyv;
      p.x2 = p.x0 + k * dxv + rand_coord($urandom_range(20, 31));
      p.y2 = p.y0 + k * dyv + rand_coord($urandom_range(20, 31));
    end else if (shape == 5) begin
      p.x2 = ($urandom_range(0, 1) != 0) ? p.x0 : p.x1;
      p.y2 = ($urandom_range(0, 1) != 0) ? p.y0 : p.y1;
    end
    return p;
  endfunction

  // Result side: random stall, one long hold-off on request.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (HoldCycles) begin
          out_stall_i <= 1'b1;
          @(negedge clk_i);
        end
      end
      out_stall_i <= idle_now();
    end
  end

  // Result checker and watchdog.
  always @(posedge clk_i) begin
    circle_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {center_x_o, center_y_o, radius_o, collinear_o, saturated_o};
      results_seen++;
      if (collinear_o) collinear_seen++;
      if (saturated_o) saturated_seen++;
      if (circles_due.size() == 0) begin
        $display("%0t: unexpected result cx=%h cy=%h r=%h col=%b sat=%b", $time,
                 got.cx, got.cy, got.rad, got.colin, got.sat);
        errors++;
      end else begin
        want = circles_due.pop_front();
        if (got.cx !== want.cx) begin
          $display("%0t: center_x expected %h actual %h", $time, want.cx, got.cx);
          errors++;
        end
        if (got.cy !== want.cy) begin
          $display("%0t: center_y expected %h actual %h", $time, want.cy, got.cy);
          errors++;
        end
        if (got.rad !== want.rad) begin
          $display("%0t: radius expected %h actual %h", $time, want.rad, got.rad);
          errors++;
        end
        if (got.colin !== want.colin) begin
          $display("%0t: collinear expected %b actual %b", $time, want.colin, got.colin);
          errors++;
        end
        if (got.sat !== want.sat) begin
          $display("%0t: saturated expected %b actual %b", $time, want.sat, got.sat);
          errors++;
        end
      end
    end
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WatchLimit) begin
      $display("%0t: no request or result moved for %0d cycles", $time, WatchLimit);
      $display("[circumcircle_xy] ERROR");
      $finish;
    end
  end

  initial begin
    row_t    rows[$];
    row_t    rw;
    circle_t zero_res;
    pts_t    p;
    int      n_sent;

    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    {first_x_i, first_y_i, second_x_i, second_y_i, third_x_i, third_y_i} = '0;
    tolerance    = '0;
    calm         = 1'b0;
    hold_req     = 1'b0;
    errors       = 0;
    results_seen = 0;
    collinear_seen = 0;
    saturated_seen = 0;
    quiet_cycles = 0;
    n_sent       = 0;
    zero_res     = '0;
    zero_res.colin = 1'b1;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table. Collinear rows carry their all-zero result by hand.
    rw.fixed = 1'b1;  rw.res = zero_res;
    rw.pts = '0;                                           rows.push_back(rw);
    rw.pts = {CMax, CMax, CMax, CMax, CMax, CMax};         rows.push_back(rw);
    rw.pts = {CMin, CMin, CMin, CMin, CMin, CMin};         rows.push_back(rw);
    rw.pts = {CMin, CMin, coord_t'(0), coord_t'(0), CMax, CMax};
    rows.push_back(rw);
    rw.pts = {One, One, 2 * One, 2 * One, -One, -One};     rows.push_back(rw);
    rw.pts = {coord_t'(5), coord_t'(-7), coord_t'(5), coord_t'(9), coord_t'(5),
              coord_t'(100)};                              rows.push_back(rw);
    rw.fixed = 1'b0;
    rw.pts = {coord_t'(0), coord_t'(0), One, coord_t'(0), coord_t'(0), One};
    rows.push_back(rw);
    // Smallest possible triangle: centre lands on a rounding tie.
    rw.pts = {coord_t'(0), coord_t'(0), coord_t'(1), coord_t'(0), coord_t'(0),
              coord_t'(1)};                                rows.push_back(rw);
    rw.pts = {coord_t'(-1), coord_t'(-1), coord_t'(-2), coord_t'(-1), coord_t'(-1),
              coord_t'(-3)};                               rows.push_back(rw);
    rw.pts = {CMin, CMin, CMax, CMin, CMin, CMax};         rows.push_back(rw);
    rw.pts = {CMax, CMax, CMin, CMax, CMax, CMin};         rows.push_back(rw);
    rw.pts = {CMax, CMin, CMin, CMax, CMax, CMax};         rows.push_back(rw);
    rw.pts = {CMin, coord_t'(0), CMax, coord_t'(0), coord_t'(0), CMax};
    rows.push_back(rw);
    rw.pts = {-One, coord_t'(0), One, coord_t'(0), coord_t'(0), One};
    rows.push_back(rw);
    // A long, thin triangle; its centre and radius stay in range.
    rw.pts = {coord_t'(0), coord_t'(0), CMax, coord_t'(0), coord_t'(1), coord_t'(1)};
    rows.push_back(rw);
    rw.pts = {coord_t'(0), coord_t'(0), One, One, 2 * One, 2 * One + 1};
    rows.push_back(rw);
    rw.pts = {3 * One, -4 * One, -5 * One, coord_t'(0), coord_t'(0), 5 * One};
    rows.push_back(rw);
    rw.pts = {coord_t'(32'h1234_5678), coord_t'(32'h8765_4321), coord_t'(32'h0f0f_0f0f),
              coord_t'(32'hf0f0_f0f0), coord_t'(32'h5555_5555), coord_t'(32'haaaa_aaaa)};
    rows.push_back(rw);

    foreach (rows[i]) begin
      send_request(rows[i].pts, rows[i].fixed, rows[i].res);
      n_sent++;
    end

    // Random phases, one per tolerance setting: zero, the largest value, a
    // moderate one and a random one. The first phase runs without idling and
    // the second carries the long output hold-off.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_tolerance('0);
        1: set_tolerance('1);
        2: set_tolerance(32'h0100_0000);
        default: set_tolerance($urandom);
      endcase
      calm = (ph == 0);
      for (int k = 0; k < RandPerPhase; k++) begin
        if (ph == 1 && k == 50) hold_req = 1'b1;
        p = random_points();
        send_request(p, 1'b0, zero_res);
        n_sent++;
      end
    end

    calm = 1'b0;
    drain();

    $display("Sent %0d triangles over four tolerance settings; %0d results checked,",
             n_sent, results_seen);
    $display("%0d of them collinear and %0d saturated.", collinear_seen, saturated_seen);
    if (errors == 0 && circles_due.size() == 0) begin
      $display("[circumcircle_xy] OK");
    end else begin
      $display("[circumcircle_xy] ERROR");
    end
    $finish;
  end

endmodule
